### hw/rtl/dat_pkg.sv
// shared types and constants for the daily alarm table
// no dependencies; imported by every module of the block except dat_ram
package dat_pkg;

	localparam int MAX_ENTRIES   = 8;
	localparam int TICKS_PER_DAY = 86400000;
	localparam int MS_PER_HOUR   = 60 * 60 * 1000;
	localparam int MS_PER_MINUTE = 60 * 1000;

	localparam int TIME_W  = 27;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int FIRED_W = 3;
	localparam int COUNT_W = 4;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	localparam int HOUR_MAX   = 23;
	localparam int MINUTE_MAX = 59;

	localparam logic KIND_BOOK = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic              fired;
		logic [TIME_W-1:0] ms;
	} entry_t;

endpackage

### hw/rtl/dat_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module dat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/dat_conv.sv
// registered conversion of an alarm hour and minute into ms since midnight
// depends on dat_pkg
module dat_conv import dat_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [HOUR_W-1:0] hour,
	input  logic [MIN_W-1:0]  minute,
	output logic [TIME_W-1:0] ms_q
);

	logic [HOUR_W-1:0] hour_sat;
	logic [MIN_W-1:0]  minute_sat;
	logic [TIME_W-1:0] hour_ms;
	logic [TIME_W-1:0] minute_ms;

	// out-of-range hour and minute saturate before the conversion
	always_comb begin
		hour_sat   = (hour > HOUR_W'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : hour;
		minute_sat = (minute > MIN_W'(MINUTE_MAX)) ? MIN_W'(MINUTE_MAX) : minute;
		hour_ms    = TIME_W'(hour_sat) * TIME_W'(MS_PER_HOUR);
		minute_ms  = TIME_W'(minute_sat) * TIME_W'(MS_PER_MINUTE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ms_q <= hour_ms + minute_ms;
		end
	end

endmodule

### hw/rtl/daily_alarm_table_unit.sv
// daily alarm table: book sequencer, tick scan over the entry ram, result register
// book: the transfer passes S_BOOK and S_OUT before the result is valid; tick: the scan stops at the
// first due entry or at the end of the table, and is a one-entry-per-cycle read-modify-write scan
// one item in flight; the next is taken once the result is loaded into the output register
// reset clears the time, entry count and control; entry ram contents are left undefined
// depends on dat_pkg, dat_ram, dat_conv
module daily_alarm_table_unit import dat_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [HOUR_W-1:0]  hour,
	input  logic [MIN_W-1:0]   minute,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               dispense,
	output logic [FIRED_W-1:0] fired_entry,
	output logic               book_accepted,
	output logic [COUNT_W-1:0] entry_count,
	output logic [TIME_W-1:0]  time_of_day
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_BOOK = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]        state_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  issue_q;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic              disp_q;
	logic [IDX_W-1:0]  fidx_q;
	logic              acc_q;

	logic               out_valid_q;
	logic               dispense_q;
	logic [FIRED_W-1:0] fired_entry_q;
	logic               book_accepted_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [TIME_W-1:0]  time_of_day_q;

	logic              in_xfer;
	logic              out_load;
	logic [TIME_W-1:0] now_next;
	logic [TIME_W-1:0] book_ms;
	logic              full;
	logic              hit;
	logic              issue;
	logic              scan_done;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;

	dat_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dat_conv u_conv (
		.clk   (clk),
		.en    (in_xfer),
		.hour  (hour),
		.minute(minute),
		.ms_q  (book_ms)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign now_next = (now_q == TIME_W'(TICKS_PER_DAY - 1)) ? '0 : now_q + 1'b1;

	// scan: read entry i while entry i-1 is checked and written back
	always_comb begin
		hit       = (state_q == S_SCAN) && chk_vld_s1 && (ram_rdata.ms < now_q)
			&& !ram_rdata.fired;
		issue     = (state_q == S_SCAN) && !hit && (issue_q < count_q);
		scan_done = (state_q == S_SCAN) && !hit && !chk_vld_s1 && (issue_q >= count_q);

		ram_re    = issue;
		ram_raddr = issue_q[IDX_W-1:0];

		ram_we          = 1'b0;
		ram_waddr       = chk_idx_s1;
		ram_wdata.ms    = ram_rdata.ms;
		ram_wdata.fired = 1'b1;
		case (state_q)
			S_BOOK: begin
				ram_we          = !full;
				ram_waddr       = count_q[IDX_W-1:0];
				ram_wdata.ms    = book_ms;
				ram_wdata.fired = !(book_ms > now_q);
			end
			S_SCAN: begin
				if (chk_vld_s1) begin
					if (ram_rdata.ms >= now_q) begin
						// entry not yet due: rearm it
						ram_we          = 1'b1;
						ram_wdata.fired = 1'b0;
					end else if (hit) begin
						ram_we = 1'b1;
					end
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= '0;
			count_q    <= '0;
			issue_q    <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			disp_q     <= 1'b0;
			fidx_q     <= '0;
			acc_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						disp_q     <= 1'b0;
						fidx_q     <= '0;
						acc_q      <= 1'b0;
						issue_q    <= '0;
						chk_vld_s1 <= 1'b0;
						if (kind == KIND_TICK) begin
							now_q   <= now_next;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_BOOK;
						end
					end
				end
				S_BOOK: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
						acc_q   <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					chk_vld_s1 <= issue;
					if (issue) begin
						chk_idx_s1 <= issue_q[IDX_W-1:0];
						issue_q    <= issue_q + 1'b1;
					end
					if (hit) begin
						disp_q  <= 1'b1;
						fidx_q  <= chk_idx_s1;
						state_q <= S_OUT;
					end else if (scan_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dispense_q      <= disp_q;
			fired_entry_q   <= FIRED_W'(fidx_q);
			book_accepted_q <= acc_q;
			entry_count_q   <= COUNT_W'(count_q);
			time_of_day_q   <= now_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign dispense      = dispense_q;
	assign fired_entry   = fired_entry_q;
	assign book_accepted = book_accepted_q;
	assign entry_count   = entry_count_q;
	assign time_of_day   = time_of_day_q;

endmodule

### hw/rtl/dat_checker.sv
// port-level checks for the daily alarm table, bound to the top level
// depends on dat_pkg and daily_alarm_table_unit
module dat_checker import dat_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               dispense,
	input logic [FIRED_W-1:0] fired_entry,
	input logic               book_accepted,
	input logic [COUNT_W-1:0] entry_count,
	input logic [TIME_W-1:0]  time_of_day
);

	// a stalled result transfer keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dispense)
			&& $stable(fired_entry) && $stable(book_accepted)
			&& $stable(entry_count) && $stable(time_of_day))
		else $error("result changed while stalled");

	// a result never shows both a dispense and an accepted book
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(dispense && book_accepted))
		else $error("dispense and book_accepted both set");

	// a fired entry is one of the stored entries
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dispense |-> (fired_entry < entry_count))
		else $error("fired entry beyond stored count");

	// time of day stays within one day
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (time_of_day < TIME_W'(TICKS_PER_DAY)))
		else $error("time of day out of range");

	// a booked entry always leaves at least one entry stored
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && book_accepted |-> (entry_count != '0))
		else $error("book accepted with empty table");

endmodule

bind daily_alarm_table_unit dat_checker u_dat_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.dispense     (dispense),
	.fired_entry  (fired_entry),
	.book_accepted(book_accepted),
	.entry_count  (entry_count),
	.time_of_day  (time_of_day)
);

### tb/alarm_tb_pkg.sv
`timescale 1ns / 1ps
// result struct and expected-result tracker for the daily alarm table bench
// depends on dat_pkg for widths, limits and the item kind codes
package alarm_tb_pkg;
	import dat_pkg::*;

	typedef struct packed {
		logic               dispense;
		logic [FIRED_W-1:0] fired_entry;
		logic               book_accepted;
		logic [COUNT_W-1:0] entry_count;
		logic [TIME_W-1:0]  time_of_day;
	} alarm_result_t;

	class alarm_tracker;
		bit [TIME_W-1:0] cur_ms;
		bit [TIME_W-1:0] slot_ms [MAX_ENTRIES];
		bit              slot_done [MAX_ENTRIES];
		int unsigned     slot_count;
		alarm_result_t   due_results [$];
		int unsigned     errors;

		function new();
			cur_ms = '0;
			slot_count = 0;
			errors = 0;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// advance the table by one accepted transfer and queue what the block must answer
		function void note_item(logic kind, logic [HOUR_W-1:0] hour, logic [MIN_W-1:0] minute);
			int unsigned h;
			int unsigned m;
			int unsigned t;
			int unsigned nxt;
			alarm_result_t r;
			r = '0;
			if (kind == KIND_BOOK) begin
				h = (hour > HOUR_MAX) ? HOUR_MAX : hour;
				m = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;
				if (slot_count < MAX_ENTRIES) begin
					t = h * MS_PER_HOUR + m * MS_PER_MINUTE;
					slot_ms[slot_count] = t[TIME_W-1:0];
					// not later than now: counts as already fired
					slot_done[slot_count] = (t <= cur_ms);
					slot_count++;
					r.book_accepted = 1'b1;
				end
			end else begin
				nxt = cur_ms + 1;
				if (nxt >= TICKS_PER_DAY)
					nxt = 0;
				cur_ms = nxt[TIME_W-1:0];
				for (int i = 0; i < slot_count; i++) begin
					if (slot_ms[i] < cur_ms) begin
						if (!slot_done[i]) begin
							slot_done[i] = 1'b1;
							r.dispense = 1'b1;
							r.fired_entry = FIRED_W'(i);
							break;
						end
					end else begin
						slot_done[i] = 1'b0;
					end
				end
			end
			r.entry_count = COUNT_W'(slot_count);
			r.time_of_day = cur_ms;
			due_results.push_back(r);
		endfunction

		function void field_diff(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(alarm_result_t got);
			alarm_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending, expected none actual %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			field_diff("dispense", want.dispense, got.dispense);
			field_diff("fired_entry", want.fired_entry, got.fired_entry);
			field_diff("book_accepted", want.book_accepted, got.book_accepted);
			field_diff("entry_count", want.entry_count, got.entry_count);
			field_diff("time_of_day", want.time_of_day, got.time_of_day);
		endfunction
	endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// top of the daily alarm table bench: clock, reset, item driver and result monitor
// depends on dat_pkg, alarm_tb_pkg and daily_alarm_table_unit
module tb_top;
	import dat_pkg::*;
	import alarm_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AT      = 61000;
	localparam int PAUSE_AT     = 1200;
	localparam int DRAIN_CYCLES = 16;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_BOOK;
	logic [HOUR_W-1:0]  hour = '0;
	logic [MIN_W-1:0]   minute = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               dispense;
	logic [FIRED_W-1:0] fired_entry;
	logic               book_accepted;
	logic [COUNT_W-1:0] entry_count;
	logic [TIME_W-1:0]  time_of_day;

	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;
	bit          fast_run = 1'b0;
	int unsigned cycles = 0;
	int unsigned results_seen = 0;
	alarm_tracker tracker;

	daily_alarm_table_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.hour          (hour),
		.minute        (minute),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dispense      (dispense),
		.fired_entry   (fired_entry),
		.book_accepted (book_accepted),
		.entry_count   (entry_count),
		.time_of_day   (time_of_day)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	function automatic int unsigned draw_gap(bit burst);
		return (burst || fast_run) ? 0 : $urandom_range(0, 18);
	endfunction

	// offer one item at a falling edge and hold it until the transfer
	task automatic send_item(input logic k, input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m);
		int unsigned gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		hour <= h;
		minute <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tracker.note_item(k, h, m);
		@(negedge clk);
	endtask

	initial begin
		int unsigned hold;
		alarm_result_t got;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (results_seen % 50 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			// one long hold-off so the block backs up onto its input
			hold = (results_seen == HOLD_AT) ? LONG_HOLD : draw_gap(recv_burst);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got = {dispense, fired_entry, book_accepted, entry_count, time_of_day};
			tracker.check_result(got);
			results_seen++;
			@(negedge clk);
		end
	end

	initial begin
		logic              k;
		logic [HOUR_W-1:0] h;
		logic [MIN_W-1:0]  m;
		tracker = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(KIND_BOOK, 5'd0, 6'd0);    // midnight at time zero starts fired
		send_item(KIND_TICK, 5'd31, 6'd63);  // tick ignores hour and minute
		send_item(KIND_BOOK, 5'd31, 6'd63);  // both saturate to 23:59
		send_item(KIND_BOOK, 5'd23, 6'd59);
		send_item(KIND_BOOK, 5'd0, 6'd60);   // minute saturates
		send_item(KIND_BOOK, 5'd24, 6'd0);   // hour saturates
		send_item(KIND_BOOK, 5'd0, 6'd1);
		send_item(KIND_TICK, 5'd0, 6'd0);

		// back-to-back ticks up to one minute so the 00:01 entries come due
		fast_run = 1'b1;
		while (tracker.cur_ms < 59999)
			send_item(KIND_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
		send_item(KIND_BOOK, 5'd0, 6'd1);    // one ms ahead of now
		send_item(KIND_TICK, 5'd0, 6'd0);    // time equals the entry: not past yet
		send_item(KIND_BOOK, 5'd0, 6'd1);    // equal to now starts fired, fills the table
		send_item(KIND_BOOK, 5'd5, 6'd5);    // refused on a full table
		repeat (4) send_item(KIND_TICK, 5'd31, 6'd0);
		fast_run = 1'b0;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				send_burst = ($urandom_range(0, 3) == 0);
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (tracker.pending() != 0);
			end
			k = ($urandom_range(0, 99) < 35) ? KIND_BOOK : KIND_TICK;
			h = HOUR_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
				: $urandom_range(0, 23));
			m = MIN_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, 59));
			send_item(k, h, m);
		end
		in_valid <= 1'b0;

		while (tracker.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
